@@ rtl/core/rdr_pkg.sv @@
// Package for the route discovery retry machine.
// It holds the phase and action codes, the register indexes and the shared structs.
// It depends on nothing else.
`timescale 1ns / 1ps

package rdr_pkg;

    // Phase codes as they appear on the phase output.
    localparam logic [1:0] PHASE_IDLE       = 2'd0;
    localparam logic [1:0] PHASE_REQUESTING = 2'd1;
    localparam logic [1:0] PHASE_COMPLETE   = 2'd2;
    localparam logic [1:0] PHASE_FAILED     = 2'd3;

    // Action codes of an input word. The fourth code is unused and changes nothing.
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic REG_TIMEOUT_MS  = 1'b0;
    localparam logic REG_MAX_RETRIES = 1'b1;

    // Register reset values.
    localparam logic [31:0] TIMEOUT_MS_RESET  = 32'd1000;
    localparam logic [7:0]  MAX_RETRIES_RESET = 8'd3;

    // One input word after the input register.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] dest_network;
        logic [15:0] dest_node;
        logic [31:0] request_id;
        logic [31:0] dest_sequence;
        logic [7:0]  hop_limit;
        logic [31:0] now_ms;
    } rdr_item_t;

    // Discovery state that is carried from one word to the next.
    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] target_network;
        logic [15:0] target_node;
        logic [31:0] wanted_sequence;
        logic [7:0]  retry_tally;
        logic [31:0] deadline;
    } rdr_state_t;

    // One result word.
    typedef struct packed {
        logic       accepted;
        logic [1:0] phase;
        logic [7:0] retries_used;
    } rdr_result_t;

    // True when a is at or after b in 32-bit serial arithmetic.
    function automatic logic serial_at_or_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        begin
            diff = a - b;
            serial_at_or_after = ~diff[31];
        end
    endfunction

endpackage

@@ rtl/core/route_discovery_retry_fsm_core.sv @@
// Route discovery retry machine, top level.
// A word passes from the input register to the result register; out_stall can hold either.
// Throughput: one word per cycle while out_stall is low; the discovery state is updated in the same cycle.
// Reset (rst_n low, asynchronous): phase idle, all discovery state zero, timeout_ms 1000,
// max_retries 3, both stages empty. No clearing pass is needed.
// Uses rdr_pkg and rdr_step.
`timescale 1ns / 1ps

module route_discovery_retry_fsm_core
    import rdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] dest_network,
    input  logic [15:0] dest_node,
    input  logic [31:0] request_id,
    input  logic [31:0] dest_sequence,
    input  logic [7:0]  hop_limit,
    input  logic [31:0] now_ms,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [1:0]  phase,
    output logic [7:0]  retries_used
);

    logic [31:0] timeout_ms_reg;
    logic [7:0]  max_retries_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    rdr_item_t   s1_item_reg;

    rdr_state_t  state_reg;
    rdr_state_t  state_next;
    rdr_result_t step_result;

    logic        out_valid_reg;
    logic        out_valid_next;
    rdr_result_t out_result_reg;

    logic        in_take;
    logic        s1_go;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg  <= TIMEOUT_MS_RESET;
            max_retries_reg <= MAX_RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data;
                REG_MAX_RETRIES: max_retries_reg <= cfg_data[7:0];
                default:         timeout_ms_reg  <= timeout_ms_reg;
            endcase
        end
    end

    // Stage handshake: the input register moves on whenever the result register is free.
    assign s1_go          = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !s1_go;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_go);
    assign out_valid_next = s1_go || (out_valid_reg && out_stall);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.action        <= action;
            s1_item_reg.dest_network  <= dest_network;
            s1_item_reg.dest_node     <= dest_node;
            s1_item_reg.request_id    <= request_id;
            s1_item_reg.dest_sequence <= dest_sequence;
            s1_item_reg.hop_limit     <= hop_limit;
            s1_item_reg.now_ms        <= now_ms;
        end
    end

    // Next state and result for the word in the input register.
    rdr_step u_step (
        .item        (s1_item_reg),
        .cur         (state_reg),
        .timeout_ms  (timeout_ms_reg),
        .max_retries (max_retries_reg),
        .nxt         (state_next),
        .result      (step_result)
    );

    // Discovery state; request id and hop limit are only checked, never read back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_go)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_result_reg.accepted;
    assign phase        = out_result_reg.phase;
    assign retries_used = out_result_reg.retries_used;

endmodule

@@ rtl/core/rdr_step.sv @@
// Next-state and result logic for one word of the route discovery retry machine.
// Purely combinational; uses the types and codes of rdr_pkg.
`timescale 1ns / 1ps

module rdr_step
    import rdr_pkg::*;
(
    input  rdr_item_t   item,
    input  rdr_state_t  cur,
    input  logic [31:0] timeout_ms,
    input  logic [7:0]  max_retries,
    output rdr_state_t  nxt,
    output rdr_result_t result
);

    logic        ids_valid;
    logic        start_ok;
    logic        reply_ok;
    logic        deadline_hit;
    logic        accepted;
    logic [31:0] new_deadline;

    // Shared decode of the word against the current state.
    assign ids_valid    = (item.dest_network != 16'd0) && (item.dest_node != 16'd0);
    assign new_deadline = item.now_ms + timeout_ms;
    assign start_ok     = ids_valid && (item.request_id != 32'd0)
                          && (item.hop_limit != 8'd0) && (cur.phase != PHASE_REQUESTING);
    assign reply_ok     = (cur.phase == PHASE_REQUESTING) && ids_valid
                          && (item.dest_network == cur.target_network)
                          && (item.dest_node == cur.target_node)
                          && serial_at_or_after(item.dest_sequence, cur.wanted_sequence);
    assign deadline_hit = (cur.phase == PHASE_REQUESTING)
                          && serial_at_or_after(item.now_ms, cur.deadline);

    // Phase transitions per action.
    always_comb
    begin
        nxt      = cur;
        accepted = 1'b0;
        case (item.action)
            ACT_START:
            begin
                if (start_ok)
                begin
                    nxt.phase           = PHASE_REQUESTING;
                    nxt.target_network  = item.dest_network;
                    nxt.target_node     = item.dest_node;
                    nxt.wanted_sequence = item.dest_sequence;
                    nxt.retry_tally     = 8'd0;
                    nxt.deadline        = new_deadline;
                    accepted            = 1'b1;
                end
            end
            ACT_REPLY:
            begin
                if (reply_ok)
                begin
                    nxt.phase = PHASE_COMPLETE;
                    accepted  = 1'b1;
                end
            end
            ACT_TIMEOUT:
            begin
                if (deadline_hit)
                begin
                    if (cur.retry_tally >= max_retries)
                    begin
                        nxt.phase = PHASE_FAILED;
                    end
                    else
                    begin
                        nxt.retry_tally = cur.retry_tally + 8'd1;
                        nxt.deadline    = new_deadline;
                        accepted        = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Result word reflects the state after the action.
    assign result.accepted     = accepted;
    assign result.phase        = nxt.phase;
    assign result.retries_used = nxt.retry_tally;

endmodule

@@ rtl/core/rdr_checker.sv @@
// Port-level checks for the route discovery retry machine, bound to its top level.
// Uses the phase codes of rdr_pkg.
`timescale 1ns / 1ps

module rdr_checker
    import rdr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       accepted,
    input logic [1:0] phase,
    input logic [7:0] retries_used
);

    // A stalled result word stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its contents.
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(accepted) && $stable(phase) && $stable(retries_used))
        else $error("result word changed while stalled");

    // An accepted action always leaves discovery requesting or complete.
    a_accept_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> (phase == PHASE_REQUESTING) || (phase == PHASE_COMPLETE))
        else $error("accepted word reports idle or failed phase");

    // Idle is only seen before the first start, so no retries can be counted.
    a_idle_retries: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == PHASE_IDLE) |-> (retries_used == 8'd0) && !accepted)
        else $error("idle phase with retries or accepted flag");

endmodule

bind route_discovery_retry_fsm_core rdr_checker u_rdr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .phase        (phase),
    .retries_used (retries_used)
);

@@ bench/tb_top.sv @@
// Self-checking bench for route_discovery_retry_fsm_core: a queue-fed driver,
// a checking monitor and a local copy of the discovery state that predicts every result word.
// Depends on rdr_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;

    import rdr_pkg::*;

    // The fourth action code has no name in the package.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int LONG_HOLD_AT = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [1:0]  phase;
    logic [7:0]  retries_used;
    rdr_item_t   offered_word = '0;

    // Words waiting to be sent and results predicted for accepted words.
    rdr_item_t   pending_words[$];
    rdr_result_t predicted_outcomes[$];

    // Local copy of the discovery state and of the two registers.
    logic [1:0]  disc_phase = PHASE_IDLE;
    logic [15:0] tgt_network = '0;
    logic [15:0] tgt_node = '0;
    logic [31:0] want_seq = '0;
    logic [7:0]  tally = '0;
    logic [31:0] due_ms = '0;
    logic [31:0] tmo_ms = TIMEOUT_MS_RESET;
    logic [7:0]  retry_cap = MAX_RETRIES_RESET;

    // Bench bookkeeping.
    logic        calm = 1'b0;
    logic        hold_done = 1'b0;
    int          send_gap = 0;
    int          stall_gap = 0;
    int          hold_left = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          words_queued = 0;
    logic [31:0] gen_clock = '0;

    route_discovery_retry_fsm_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (offered_word.action),
        .dest_network (offered_word.dest_network),
        .dest_node    (offered_word.dest_node),
        .request_id   (offered_word.request_id),
        .dest_sequence(offered_word.dest_sequence),
        .hop_limit    (offered_word.hop_limit),
        .now_ms       (offered_word.now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .phase        (phase),
        .retries_used (retries_used)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one accepted word to the local discovery state and returns its result.
    function automatic rdr_result_t advance_discovery(input rdr_item_t w);
        rdr_result_t r;
        logic [31:0] lag;
        logic        granted;
        begin
            granted = 1'b0;
            case (w.action)
                ACT_START:
                begin
                    if (w.dest_network != '0 && w.dest_node != '0 && w.request_id != '0 &&
                        w.hop_limit != '0 && disc_phase != PHASE_REQUESTING)
                    begin
                        disc_phase = PHASE_REQUESTING;
                        tgt_network = w.dest_network;
                        tgt_node = w.dest_node;
                        want_seq = w.dest_sequence;
                        tally = '0;
                        due_ms = w.now_ms + tmo_ms;
                        granted = 1'b1;
                    end
                end
                ACT_REPLY:
                begin
                    // Serial compare: the reply is newer or equal when the difference is below half range.
                    lag = w.dest_sequence - want_seq;
                    if (disc_phase == PHASE_REQUESTING && w.dest_network != '0 &&
                        w.dest_node != '0 && w.dest_network == tgt_network &&
                        w.dest_node == tgt_node && !lag[31])
                    begin
                        disc_phase = PHASE_COMPLETE;
                        granted = 1'b1;
                    end
                end
                ACT_TIMEOUT:
                begin
                    lag = w.now_ms - due_ms;
                    if (disc_phase == PHASE_REQUESTING && !lag[31])
                    begin
                        if (tally >= retry_cap)
                        begin
                            disc_phase = PHASE_FAILED;
                        end
                        else
                        begin
                            tally = tally + 8'd1;
                            due_ms = w.now_ms + tmo_ms;
                            granted = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.accepted = granted;
            r.phase = disc_phase;
            r.retries_used = tally;
            return r;
        end
    endfunction

    // Queues one input word.
    task automatic queue_word(input logic [1:0] act, input logic [15:0] net,
                              input logic [15:0] node, input logic [31:0] req,
                              input logic [31:0] seq, input logic [7:0] hops,
                              input logic [31:0] stamp);
        rdr_item_t w;
        begin
            w.action = act;
            w.dest_network = net;
            w.dest_node = node;
            w.request_id = req;
            w.dest_sequence = seq;
            w.hop_limit = hops;
            w.now_ms = stamp;
            pending_words.push_back(w);
            words_queued++;
        end
    endtask

    // Fully random word; a quarter of the time one id field is forced to zero.
    task automatic queue_noise();
        logic [15:0] net;
        logic [15:0] node;
        logic [31:0] req;
        logic [7:0]  hops;
        begin
            net = 16'($urandom);
            node = 16'($urandom);
            req = $urandom;
            hops = 8'($urandom);
            case ($urandom_range(0, 7))
                0: net = '0;
                1: node = '0;
                default:
                begin
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                req = '0;
            if ($urandom_range(0, 7) == 0)
                hops = '0;
            queue_word(2'($urandom_range(0, 3)), net, node, req, $urandom, hops, $urandom);
        end
    endtask

    // One discovery: a start, a mix of timeouts, replies, other starts and noise, then a closing reply
    // or enough late timeouts to run out of retries; a noise word may come before the start.
    task automatic plan_discovery();
        logic [15:0] net;
        logic [15:0] node;
        logic [31:0] seq;
        logic [31:0] due_guess;
        logic [31:0] stamp;
        int          pick;
        begin
            net = 16'($urandom_range(1, 16'hFFFF));
            node = 16'($urandom_range(1, 16'hFFFF));
            seq = $urandom;
            gen_clock = gen_clock + $urandom_range(0, 5000);
            if ($urandom_range(0, 9) == 0)
                queue_noise();
            queue_word(ACT_START, net, node, $urandom_range(1, 32'hFFFF_FFFF), seq,
                       8'($urandom_range(1, 255)), gen_clock);
            due_guess = gen_clock + tmo_ms;
            repeat ($urandom_range(0, 10))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        stamp = due_guess + $urandom_range(0, 3);
                        due_guess = stamp + tmo_ms;
                    end
                    else
                    begin
                        stamp = due_guess - $urandom_range(1, 500);
                    end
                    gen_clock = stamp;
                    queue_word(ACT_TIMEOUT, 16'($urandom), 16'($urandom), $urandom, $urandom,
                               8'($urandom), stamp);
                end
                else if (pick < 60)
                begin
                    // Matching target, older sequence.
                    queue_word(ACT_REPLY, net, node, $urandom, seq - $urandom_range(1, 1000),
                               8'($urandom), gen_clock);
                end
                else if (pick < 75)
                begin
                    // One bit off in the network or node id.
                    if ($urandom_range(0, 1) == 0)
                        queue_word(ACT_REPLY, net ^ (16'd1 << $urandom_range(0, 15)), node,
                                   $urandom, seq, 8'($urandom), gen_clock);
                    else
                        queue_word(ACT_REPLY, net, node ^ (16'd1 << $urandom_range(0, 15)),
                                   $urandom, seq, 8'($urandom), gen_clock);
                end
                else if (pick < 85)
                begin
                    queue_word(ACT_START, 16'($urandom_range(1, 16'hFFFF)),
                               16'($urandom_range(1, 16'hFFFF)),
                               $urandom_range(1, 32'hFFFF_FFFF), $urandom,
                               8'($urandom_range(1, 255)), gen_clock);
                end
                else
                begin
                    queue_noise();
                end
            end
            if ($urandom_range(0, 99) < 35 && retry_cap < 8)
            begin
                repeat (int'(retry_cap) + 1)
                begin
                    stamp = due_guess + $urandom_range(0, 3);
                    due_guess = stamp + tmo_ms;
                    gen_clock = stamp;
                    queue_word(ACT_TIMEOUT, 16'($urandom), 16'($urandom), $urandom, $urandom,
                               8'($urandom), stamp);
                end
            end
            else
            begin
                queue_word(ACT_REPLY, net, node, $urandom, seq + $urandom_range(0, 1000),
                           8'($urandom), gen_clock);
            end
        end
    endtask

    // Writes one register while the block is idle.
    task automatic write_register(input logic idx, input logic [31:0] value);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            if (idx == REG_TIMEOUT_MS)
                tmo_ms = value;
            else
                retry_cap = value[7:0];
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Waits until every queued word is sent and every predicted result has arrived.
    task automatic wait_drained();
        begin
            do
                @(negedge clk);
            while (pending_words.size() != 0 || in_valid || predicted_outcomes.size() != 0);
            repeat (4) @(negedge clk);
        end
    endtask

    // One random phase under the given register settings.
    task automatic run_phase(input logic [31:0] timeout_val, input logic [7:0] retries_val,
                             input int n_words, input logic quiet);
        int first;
        begin
            write_register(REG_TIMEOUT_MS, timeout_val);
            write_register(REG_MAX_RETRIES, {24'd0, retries_val});
            @(negedge clk);
            calm = quiet;
            gen_clock = $urandom;
            first = words_queued;
            while (words_queued - first < n_words)
                plan_discovery();
            wait_drained();
        end
    endtask

    // Stimulus: reset, directed and random words at reset settings, then random phases.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Rejections while idle and starts with a zero id, hop limit or request.
        queue_word(ACT_TIMEOUT, 16'd1, 16'd1, 32'd1, 32'd0, 8'd1, 32'd0);
        queue_word(ACT_REPLY, 16'd1, 16'd1, 32'd1, 32'd0, 8'd1, 32'd0);
        queue_word(ACT_START, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'd0);
        queue_word(ACT_START, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 8'hFF, 32'd0);
        queue_word(ACT_START, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'd0, 8'hFF, 32'd0);
        queue_word(ACT_START, 16'hFFFF, 16'hFFFF, 32'd0, 32'd0, 8'hFF, 32'd0);
        queue_word(ACT_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, 32'd0);
        // Start at the top of every field; the deadline wraps past zero.
        queue_word(ACT_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                   32'hFFFF_FFFF);
        queue_word(ACT_START, 16'd1, 16'd1, 32'd1, 32'd1, 8'd1, 32'd0);
        // One short of the deadline, then exactly on it.
        queue_word(ACT_TIMEOUT, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'h0000_03E6);
        queue_word(ACT_TIMEOUT, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'h0000_03E7);
        queue_word(ACT_REPLY, 16'hFFFF, 16'hFFFE, 32'd0, 32'hFFFF_FFFF, 8'd0, 32'd0);
        queue_word(ACT_REPLY, 16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFE, 8'd0, 32'd0);
        queue_word(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                   32'hFFFF_FFFF);
        // Use up the retries, then fail.
        queue_word(ACT_TIMEOUT, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'h0000_07CF);
        queue_word(ACT_TIMEOUT, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'h0000_0BB7);
        queue_word(ACT_TIMEOUT, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'h0000_0F9F);
        queue_word(ACT_TIMEOUT, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0, 32'h000F_FFFF);
        // Restart from failed; a reply half a range ahead is not newer, an equal one is.
        queue_word(ACT_START, 16'd1, 16'd1, 32'd1, 32'h7FFF_FFFF, 8'd1, 32'd0);
        queue_word(ACT_REPLY, 16'd1, 16'd1, 32'd0, 32'hFFFF_FFFF, 8'd0, 32'd0);
        queue_word(ACT_REPLY, 16'd1, 16'd1, 32'd0, 32'h7FFF_FFFF, 8'd0, 32'd0);
        queue_word(ACT_REPLY, 16'd1, 16'd1, 32'd0, 32'h7FFF_FFFF, 8'd0, 32'd0);
        // Restart from complete.
        queue_word(ACT_START, 16'd1, 16'd1, 32'd1, 32'd0, 8'd1, 32'h8000_0000);
        while (words_queued < 225)
            plan_discovery();
        wait_drained();

        run_phase(32'd1, 8'd0, 250, 1'b0);
        run_phase(32'hFFFF_FFFF, 8'hFF, 250, 1'b0);
        run_phase($urandom_range(1, 5000), 8'($urandom_range(0, 6)), 250, 1'b0);
        run_phase(32'd5, 8'd1, 200, 1'b0);
        run_phase(32'd1000, 8'd2, 200, 1'b1);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Driver: records accepted words in the predictor and presents the next word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predicted_outcomes.push_back(advance_discovery(offered_word));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 99) < 8)
                    begin
                        in_valid <= 1'b0;
                        send_gap <= $urandom_range(0, 8);
                    end
                    else
                    begin
                        offered_word <= pending_words.pop_front();
                        in_valid <= 1'b1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction and drives stall.
    always @(posedge clk)
    begin
        rdr_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (predicted_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result word accepted %0d phase %0d retries %0d",
                             $time, accepted, phase, retries_used);
                    mismatches++;
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (accepted !== want.accepted)
                    begin
                        $display("%0t: accepted expected %0d actual %0d",
                                 $time, want.accepted, accepted);
                        mismatches++;
                    end
                    if (phase !== want.phase)
                    begin
                        $display("%0t: phase expected %0d actual %0d", $time, want.phase, phase);
                        mismatches++;
                    end
                    if (retries_used !== want.retries_used)
                    begin
                        $display("%0t: retries_used expected %0d actual %0d",
                                 $time, want.retries_used, retries_used);
                        mismatches++;
                    end
                end
            end

            // One long hold-off so the block backs up; otherwise short random bursts.
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && results_seen >= LONG_HOLD_AT)
            begin
                out_stall <= 1'b1;
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD_CYCLES - 1;
            end
            else if (stall_gap > 0)
            begin
                out_stall <= 1'b1;
                stall_gap <= stall_gap - 1;
            end
            else if (!calm && $urandom_range(0, 99) < 8)
            begin
                out_stall <= 1'b1;
                stall_gap <= $urandom_range(0, 8);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ files.f @@
rtl/core/rdr_pkg.sv
rtl/core/rdr_step.sv
rtl/core/route_discovery_retry_fsm_core.sv
rtl/core/rdr_checker.sv
bench/tb_top.sv
